// ===== design/rope_pkg.sv =====
// Shared types, constants and the frequency table of the rotary position embedding block.
`default_nettype none

package rope_pkg;

    // Field widths of the item formats.
    localparam int POS_W  = 12;
    localparam int PAIR_W = 6;
    localparam int PAIRS  = 2 ** PAIR_W;

    // Model dimensions.
    localparam int HEAD_DIM      = 128;
    localparam int MAX_POSITIONS = 4096;

    // Fixed-point constants.
    localparam logic [63:0] LOG2_TENK_Q32  = (64'd13 << 32) + 64'd1235715261;
    localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;
    localparam logic [31:0] TWO_PI_Q29     = 32'd3373259426;
    localparam logic [32:0] ONE_Q32        = 33'h1_0000_0000;

    // Taylor series: one cell per term, each dividing by a fixed integer.
    // Division is done as a multiply by a rounded-up reciprocal, which is exact
    // for every 32-bit dividend.
    localparam int TERMS  = 7;
    localparam int TERM_W = 3;
    localparam int SIN_DIV [TERMS] = '{6, 20, 42, 72, 110, 156, 210};
    localparam int COS_DIV [TERMS] = '{2, 12, 30, 56, 90, 132, 182};
    localparam int SIN_LOG [TERMS] = '{3, 5, 6, 7, 7, 8, 8};
    localparam int COS_LOG [TERMS] = '{1, 4, 5, 6, 7, 8, 8};

    localparam logic [32:0] SIN_RECIP [TERMS] = '{
        33'(((64'd1 << (32 + SIN_LOG[0])) + 64'(SIN_DIV[0] - 1)) / 64'(SIN_DIV[0])),
        33'(((64'd1 << (32 + SIN_LOG[1])) + 64'(SIN_DIV[1] - 1)) / 64'(SIN_DIV[1])),
        33'(((64'd1 << (32 + SIN_LOG[2])) + 64'(SIN_DIV[2] - 1)) / 64'(SIN_DIV[2])),
        33'(((64'd1 << (32 + SIN_LOG[3])) + 64'(SIN_DIV[3] - 1)) / 64'(SIN_DIV[3])),
        33'(((64'd1 << (32 + SIN_LOG[4])) + 64'(SIN_DIV[4] - 1)) / 64'(SIN_DIV[4])),
        33'(((64'd1 << (32 + SIN_LOG[5])) + 64'(SIN_DIV[5] - 1)) / 64'(SIN_DIV[5])),
        33'(((64'd1 << (32 + SIN_LOG[6])) + 64'(SIN_DIV[6] - 1)) / 64'(SIN_DIV[6]))
    };

    localparam logic [32:0] COS_RECIP [TERMS] = '{
        33'(((64'd1 << (32 + COS_LOG[0])) + 64'(COS_DIV[0] - 1)) / 64'(COS_DIV[0])),
        33'(((64'd1 << (32 + COS_LOG[1])) + 64'(COS_DIV[1] - 1)) / 64'(COS_DIV[1])),
        33'(((64'd1 << (32 + COS_LOG[2])) + 64'(COS_DIV[2] - 1)) / 64'(COS_DIV[2])),
        33'(((64'd1 << (32 + COS_LOG[3])) + 64'(COS_DIV[3] - 1)) / 64'(COS_DIV[3])),
        33'(((64'd1 << (32 + COS_LOG[4])) + 64'(COS_DIV[4] - 1)) / 64'(COS_DIV[4])),
        33'(((64'd1 << (32 + COS_LOG[5])) + 64'(COS_DIV[5] - 1)) / 64'(COS_DIV[5])),
        33'(((64'd1 << (32 + COS_LOG[6])) + 64'(COS_DIV[6] - 1)) / 64'(COS_DIV[6]))
    };

    typedef enum logic [1:0] {
        QUAD_I,
        QUAD_II,
        QUAD_III,
        QUAD_IV
    } t_quad;

    typedef struct packed {
        logic [POS_W-1:0]  position;
        logic [PAIR_W-1:0] pair_in_head;
        logic signed [31:0] query_even;
        logic signed [31:0] query_odd;
        logic signed [31:0] key_even;
        logic signed [31:0] key_odd;
        logic               has_key;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] rot_query_even;
        logic signed [31:0] rot_query_odd;
        logic signed [31:0] rot_key_even;
        logic signed [31:0] rot_key_odd;
    } t_out_item;

    typedef struct packed {
        logic signed [31:0] query_even;
        logic signed [31:0] query_odd;
        logic signed [31:0] key_even;
        logic signed [31:0] key_odd;
        logic               has_key;
    } t_vals;

    typedef struct packed {
        t_vals vals;
        t_quad quad;
        logic  swap;
    } t_side;

    typedef struct packed {
        logic [31:0] x2;
        logic [31:0] ts;
        logic [32:0] tc;
        logic [32:0] ss;
        logic [32:0] sc;
    } t_taylor;

    typedef struct packed {
        logic    valid;
        t_taylor tay;
        t_side   side;
    } t_cell_bus;

    // Rounded integer square root, bit by bit.
    function automatic logic [63:0] sqrt_round(input logic [63:0] x_in);
        logic [63:0] x;
        logic [63:0] r;
        logic [63:0] b;
        int i;
        x = x_in;
        r = '0;
        b = 64'd1 << 62;
        for (i = 0; i < 32; i++) begin
            if (b > x) begin
                b = b >> 2;
            end
        end
        for (i = 0; i < 32; i++) begin
            if (b != 64'd0) begin
                if (x >= r + b) begin
                    x = x - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        if (x > r) begin
            r = r + 64'd1;
        end
        return r;
    endfunction

    // Inverse frequency 10000^(-k/HEAD_DIM) in Q1.31 for one pair index.
    function automatic logic [31:0] freq_q31(input int pair);
        logic [63:0] k;
        logic [63:0] x;
        logic [63:0] n;
        logic [31:0] f;
        logic [63:0] acc;
        logic [63:0] c;
        logic [63:0] q;
        int i;
        k = 64'((2 * pair) % HEAD_DIM);
        x = (k * LOG2_TENK_Q32) / 64'(HEAD_DIM);
        n = (x >> 32) & 64'd63;
        f = x[31:0];
        acc = 64'd1 << 32;
        c = sqrt_round(64'd1 << 63);
        for (i = 0; i < 32; i++) begin
            if (c > 64'h0000_0000_FFFF_FFFF) begin
                c = 64'h0000_0000_FFFF_FFFF;
            end
            if (f[31 - i]) begin
                acc = (acc * c + (64'd1 << 31)) >> 32;
            end
            c = sqrt_round(c << 32);
        end
        q = (acc + (64'd1 << n)) >> (n + 64'd1);
        return q[31:0];
    endfunction

    typedef logic [PAIRS-1:0][31:0] t_freq_rom;

    function automatic t_freq_rom build_freq_rom();
        t_freq_rom rom;
        int j;
        for (j = 0; j < PAIRS; j++) begin
            rom[j] = freq_q31(j);
        end
        return rom;
    endfunction

    localparam t_freq_rom FREQ_ROM = build_freq_rom();

endpackage

`default_nettype wire

// ===== design/rotary_position_embedding.sv =====
// Top level of the rotary position embedding rotator: angle front end, Taylor cell chain, rotator.
// Pipeline: a result passes through 5 angle stages, 7 Taylor cells of 2 stages each,
// 3 rotation stages and the output register on its way to the output.
// Throughput: one item per cycle; input ready drops only while the skid register holds a result.
// Reset: synchronous, active low; it empties every stage, the output and the skid register.
`default_nettype none

module rotary_position_embedding (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  rope_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output rope_pkg::t_out_item  o_out_data
);

    // The whole pipeline moves in lockstep on pipe_adv. Every stage carries its own
    // valid bit, so empty slots simply travel along as bubbles.
    logic                pipe_adv;
    rope_pkg::t_cell_bus chain [rope_pkg::TERMS + 1];
    logic                last_valid;
    rope_pkg::t_out_item last_item;

    // Output side: an output register plus one skid register. The pipeline keeps
    // running while the output register waits; only when the skid register is also
    // occupied does the pipeline stall.
    logic                r_out_valid;
    rope_pkg::t_out_item r_out_data;
    logic                r_skid_valid;
    rope_pkg::t_out_item r_skid_data;
    logic                n_out_valid;
    logic                n_skid_valid;
    logic                push;
    logic                take;
    logic                load_out;
    logic                load_skid;
    logic                out_from_skid;

    assign pipe_adv   = !r_skid_valid;
    assign o_in_ready = pipe_adv;

    // Angle front end: frequency table lookup, phase in turns, fold into one octant,
    // conversion to radians and the squared angle that seeds the series.
    rope_phase u_phase (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (pipe_adv),
        .i_valid (i_in_valid),
        .i_item  (i_in_data),
        .o_bus   (chain[0])
    );

    // Chain of identical cells, one per Taylor term. Each cell works out its term
    // from its neighbor's term and hands the running sums on whenever the pipeline advances.
    for (genvar g = 0; g < rope_pkg::TERMS; g++) begin : g_cell
        rope_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (pipe_adv),
            .i_term  (rope_pkg::TERM_W'(g)),
            .i_bus   (chain[g]),
            .o_bus   (chain[g + 1])
        );
    end

    // Sine and cosine are mapped to their quadrant; query and, if has_key, key are rotated.
    rope_rotate u_rotate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (pipe_adv),
        .i_bus   (chain[rope_pkg::TERMS]),
        .o_valid (last_valid),
        .o_item  (last_item)
    );

    // A finished result leaves the pipeline whenever it advances. It goes to the
    // output register if that is free or being emptied in this cycle, otherwise to
    // the skid register. The skid register drains into the output register on the
    // next transfer at the output.
    assign push = last_valid & pipe_adv;
    assign take = r_out_valid & i_out_ready;

    always_comb begin
        n_out_valid   = r_out_valid;
        n_skid_valid  = r_skid_valid;
        load_out      = 1'b0;
        load_skid     = 1'b0;
        out_from_skid = 1'b0;
        if (r_skid_valid) begin
            if (take) begin
                n_out_valid   = 1'b1;
                n_skid_valid  = 1'b0;
                load_out      = 1'b1;
                out_from_skid = 1'b1;
            end
        end else if (push) begin
            if (!r_out_valid || take) begin
                n_out_valid = 1'b1;
                load_out    = 1'b1;
            end else begin
                n_skid_valid = 1'b1;
                load_skid    = 1'b1;
            end
        end else if (take) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_data <= out_from_skid ? r_skid_data : last_item;
        end
        if (load_skid) begin
            r_skid_data <= last_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

// ===== design/rope_phase.sv =====
// Angle front end: frequency lookup, phase in turns, octant fold and the x, x^2 seed.
`default_nettype none

module rope_phase (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  logic                 i_valid,
    input  rope_pkg::t_in_item   i_item,
    output rope_pkg::t_cell_bus  o_bus
);

    localparam int PROD_W = rope_pkg::POS_W + 32;
    localparam int HI_W   = rope_pkg::POS_W + 30;

    logic [4:0]              r_valid;
    logic [PROD_W-1:0]       r1_prod;
    rope_pkg::t_vals         r1_vals;
    logic [61:0]             r2_lo;
    logic [HI_W-1:0]         r2_hi;
    rope_pkg::t_vals         r2_vals;
    logic [31:0]             r3_phase;
    rope_pkg::t_vals         r3_vals;
    logic [31:0]             r4_x;
    rope_pkg::t_side         r4_side;
    rope_pkg::t_taylor       r5_tay;
    rope_pkg::t_side         r5_side;

    logic [rope_pkg::POS_W-1:0] pos_wrap;
    logic [31:0]             freq;
    logic [PROD_W-1:0]       n1_prod;
    rope_pkg::t_vals         n1_vals;
    logic [61:0]             n2_lo;
    logic [HI_W-1:0]         n2_hi;
    logic [62:0]             n3_sum;
    logic [29:0]             rem;
    logic [29:0]             fold;
    logic [61:0]             rad_mul;
    logic [61:0]             rad_rnd;
    rope_pkg::t_side         n4_side;
    logic [63:0]             sq;
    rope_pkg::t_taylor       n5_tay;

    always_comb begin
        pos_wrap = rope_pkg::POS_W'(32'(i_item.position) % rope_pkg::MAX_POSITIONS);
        freq     = rope_pkg::FREQ_ROM[i_item.pair_in_head];
        n1_prod  = PROD_W'(pos_wrap) * PROD_W'(freq);

        n1_vals.query_even = i_item.query_even;
        n1_vals.query_odd  = i_item.query_odd;
        n1_vals.key_even   = i_item.key_even;
        n1_vals.key_odd    = i_item.key_odd;
        n1_vals.has_key    = i_item.has_key;

        n2_lo = 62'(r1_prod[31:0]) * 62'(rope_pkg::INV_TWO_PI_Q32);
        n2_hi = HI_W'(r1_prod[PROD_W-1:32]) * HI_W'(rope_pkg::INV_TWO_PI_Q32);

        // Only bits below 2^63 matter, so the high product enters at bit 32.
        n3_sum = {1'b0, r2_lo} + {r2_hi[30:0], 32'd0};

        // Second half of a quadrant folds onto the first with sine and cosine swapped.
        rem          = r3_phase[29:0];
        n4_side.vals = r3_vals;
        n4_side.quad = rope_pkg::t_quad'(r3_phase[31:30]);
        n4_side.swap = rem[29];
        fold         = rem[29] ? 30'(31'h4000_0000 - {1'b0, rem}) : rem;
        rad_mul      = 62'(fold) * 62'(rope_pkg::TWO_PI_Q29);
        rad_rnd      = rad_mul + (62'd1 << 28);

        sq        = 64'(r4_x) * 64'(r4_x) + (64'd1 << 31);
        n5_tay.x2 = sq[63:32];
        n5_tay.ts = r4_x;
        n5_tay.tc = rope_pkg::ONE_Q32;
        n5_tay.ss = {1'b0, r4_x};
        n5_tay.sc = rope_pkg::ONE_Q32;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_adv) begin
            r_valid <= {r_valid[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_prod  <= n1_prod;
            r1_vals  <= n1_vals;
            r2_lo    <= n2_lo;
            r2_hi    <= n2_hi;
            r2_vals  <= r1_vals;
            r3_phase <= n3_sum[62:31];
            r3_vals  <= r2_vals;
            r4_x     <= rad_rnd[60:29];
            r4_side  <= n4_side;
            r5_tay   <= n5_tay;
            r5_side  <= r4_side;
        end
    end

    assign o_bus.valid = r_valid[4];
    assign o_bus.tay   = r5_tay;
    assign o_bus.side  = r5_side;

endmodule

`default_nettype wire

// ===== design/rope_cell.sv =====
// One Taylor series cell: computes the next sine and cosine terms and adds them in.
`default_nettype none

module rope_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_adv,
    input  logic [rope_pkg::TERM_W-1:0]  i_term,
    input  rope_pkg::t_cell_bus          i_bus,
    output rope_pkg::t_cell_bus          o_bus
);

    logic              r_a_valid;
    logic [31:0]       r_a_x2;
    logic [31:0]       r_a_ps;
    logic [31:0]       r_a_pc;
    logic [32:0]       r_a_ss;
    logic [32:0]       r_a_sc;
    rope_pkg::t_side   r_a_side;
    logic              r_b_valid;
    rope_pkg::t_taylor r_b_tay;
    rope_pkg::t_side   r_b_side;

    logic [63:0]       n_a_ps_full;
    logic [64:0]       n_a_pc_full;
    logic [5:0]        sh_s;
    logic [5:0]        sh_c;
    logic [64:0]       n_b_qs_full;
    logic [64:0]       n_b_qc_full;
    logic [31:0]       n_b_qs;
    logic [31:0]       n_b_qc;
    logic              term_sub;
    rope_pkg::t_taylor n_b_tay;

    always_comb begin
        n_a_ps_full = 64'(i_bus.tay.ts) * 64'(i_bus.tay.x2);
        n_a_pc_full = 65'(i_bus.tay.tc) * 65'(i_bus.tay.x2);

        sh_s        = 6'(32 + rope_pkg::SIN_LOG[i_term]);
        sh_c        = 6'(32 + rope_pkg::COS_LOG[i_term]);
        n_b_qs_full = 65'(r_a_ps) * 65'(rope_pkg::SIN_RECIP[i_term]);
        n_b_qc_full = 65'(r_a_pc) * 65'(rope_pkg::COS_RECIP[i_term]);
        n_b_qs      = 32'(n_b_qs_full >> sh_s);
        n_b_qc      = 32'(n_b_qc_full >> sh_c);

        // Odd-numbered terms are subtracted; the first cell holds term one.
        term_sub    = !i_term[0];
        n_b_tay.x2  = r_a_x2;
        n_b_tay.ts  = n_b_qs;
        n_b_tay.tc  = {1'b0, n_b_qc};
        n_b_tay.ss  = term_sub ? r_a_ss - {1'b0, n_b_qs} : r_a_ss + {1'b0, n_b_qs};
        n_b_tay.sc  = term_sub ? r_a_sc - {1'b0, n_b_qc} : r_a_sc + {1'b0, n_b_qc};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else if (i_adv) begin
            r_a_valid <= i_bus.valid;
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_a_x2   <= i_bus.tay.x2;
            r_a_ps   <= n_a_ps_full[63:32];
            r_a_pc   <= n_a_pc_full[63:32];
            r_a_ss   <= i_bus.tay.ss;
            r_a_sc   <= i_bus.tay.sc;
            r_a_side <= i_bus.side;
            r_b_tay  <= n_b_tay;
            r_b_side <= r_a_side;
        end
    end

    assign o_bus.valid = r_b_valid;
    assign o_bus.tay   = r_b_tay;
    assign o_bus.side  = r_b_side;

endmodule

`default_nettype wire

// ===== design/rope_rotate.sv =====
// Rotation back end: quadrant mapping, pair products, rounding and saturation.
`default_nettype none

module rope_rotate (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  rope_pkg::t_cell_bus  i_bus,
    output logic                 o_valid,
    output rope_pkg::t_out_item  o_item
);

    logic [2:0]          r_valid;
    logic signed [31:0]  r1_cs;
    logic signed [31:0]  r1_sn;
    rope_pkg::t_vals     r1_vals;
    logic signed [63:0]  r2_qec;
    logic signed [63:0]  r2_qos;
    logic signed [63:0]  r2_qes;
    logic signed [63:0]  r2_qoc;
    logic signed [63:0]  r2_kec;
    logic signed [63:0]  r2_kos;
    logic signed [63:0]  r2_kes;
    logic signed [63:0]  r2_koc;
    rope_pkg::t_vals     r2_vals;
    rope_pkg::t_out_item r3_item;

    logic [32:0]         s_raw;
    logic [32:0]         c_raw;
    logic [33:0]         s_rnd;
    logic [33:0]         c_rnd;
    logic signed [31:0]  s_val;
    logic signed [31:0]  c_val;
    logic signed [31:0]  n1_cs;
    logic signed [31:0]  n1_sn;
    rope_pkg::t_out_item n3_item;

    // Rounds a Q.46 sum to nearest (ties upward) at Q16.16 and saturates.
    function automatic logic signed [31:0] round_sat(input logic signed [63:0] v);
        logic signed [63:0] r;
        r = (v + 64'sd536870912) >>> 30;
        if (r > 64'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (r < -64'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return r[31:0];
    endfunction

    always_comb begin
        s_raw = i_bus.side.swap ? i_bus.tay.sc : i_bus.tay.ss;
        c_raw = i_bus.side.swap ? i_bus.tay.ss : i_bus.tay.sc;
        s_rnd = 34'(s_raw) + 34'd2;
        c_rnd = 34'(c_raw) + 34'd2;
        s_val = signed'({1'b0, s_rnd[32:2]});
        c_val = signed'({1'b0, c_rnd[32:2]});
        case (i_bus.side.quad)
            rope_pkg::QUAD_I: begin
                n1_cs = c_val;
                n1_sn = s_val;
            end
            rope_pkg::QUAD_II: begin
                n1_cs = -s_val;
                n1_sn = c_val;
            end
            rope_pkg::QUAD_III: begin
                n1_cs = -c_val;
                n1_sn = -s_val;
            end
            default: begin
                n1_cs = s_val;
                n1_sn = -c_val;
            end
        endcase

        n3_item.rot_query_even = round_sat(r2_qec - r2_qos);
        n3_item.rot_query_odd  = round_sat(r2_qes + r2_qoc);
        n3_item.rot_key_even   = r2_vals.has_key ? round_sat(r2_kec - r2_kos)
                                                 : r2_vals.key_even;
        n3_item.rot_key_odd    = r2_vals.has_key ? round_sat(r2_kes + r2_koc)
                                                 : r2_vals.key_odd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_adv) begin
            r_valid <= {r_valid[1:0], i_bus.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_cs   <= n1_cs;
            r1_sn   <= n1_sn;
            r1_vals <= i_bus.side.vals;
            r2_qec  <= 64'(r1_vals.query_even) * 64'(r1_cs);
            r2_qos  <= 64'(r1_vals.query_odd) * 64'(r1_sn);
            r2_qes  <= 64'(r1_vals.query_even) * 64'(r1_sn);
            r2_qoc  <= 64'(r1_vals.query_odd) * 64'(r1_cs);
            r2_kec  <= 64'(r1_vals.key_even) * 64'(r1_cs);
            r2_kos  <= 64'(r1_vals.key_odd) * 64'(r1_sn);
            r2_kes  <= 64'(r1_vals.key_even) * 64'(r1_sn);
            r2_koc  <= 64'(r1_vals.key_odd) * 64'(r1_cs);
            r2_vals <= r1_vals;
            r3_item <= n3_item;
        end
    end

    assign o_valid = r_valid[2];
    assign o_item  = r3_item;

endmodule

`default_nettype wire

// ===== design/rope_checker.sv =====
// Port-level checker for the rotary position embedding block and its bind to the top level.
`default_nettype none

module rope_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input rope_pkg::t_out_item o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output result changed or dropped while stalled");

    a_stall_needs_full_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with an empty output register");

    a_ready_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_in_ready) |-> $past(o_out_valid && !i_out_ready))
        else $error("input stalled without a stalled output");

    a_ready_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_ready) && $past(i_rst_n) |-> $past(o_out_valid && i_out_ready))
        else $error("input stall released without an output transfer");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("block not empty after reset");

endmodule

bind rotary_position_embedding rope_checker u_rope_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

`default_nettype wire
